// ===== rtl/rvd_pkg.sv =====
// ----------------------------------------------------------------------------
// rvd_pkg
// shared types and constants for the rv64im decode/execute block
// ----------------------------------------------------------------------------
package rvd_pkg;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0]  F7_BASE  = 7'h00;
    localparam logic [6:0]  F7_MULDIV = 7'h01;
    localparam logic [6:0]  F7_ALT   = 7'h20;
    localparam logic [5:0]  SH_ALT   = 6'h10;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
    localparam logic [4:0]  REG_A0   = 5'd10;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
        OP_OR, OP_AND, OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW, OP_MUL, OP_DIV,
        OP_LINK, OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU
    } t_op;

    typedef struct packed {
        logic [4:0] dest_reg;
        logic       write_reg;
        logic       illegal;
        logic [1:0] mem_kind;
        logic [1:0] mem_size;
        logic       load_signed;
        logic       system_call;
        logic       long_latency;
    } t_info;

    typedef struct packed {
        t_op         op;
        logic [63:0] opa;
        logic [63:0] opb;
        logic [63:0] target;
        logic [63:0] link;
        logic [63:0] store_data;
        t_info       info;
    } t_uop;

endpackage

// ===== rtl/rv64im_decode_execute.sv =====
// ----------------------------------------------------------------------------
// rv64im_decode_execute
// path: queue, then the output stage registers; a div passes the divider in between
// throughput: one instruction per cycle when no div runs; a div holds the back end
// until it ends and the queue absorbs the front while it runs
// reset: synchronous, clears queue pointers, divider and output strobe
// results are strobed for one cycle on o_valid; the receiver cannot stall
// ----------------------------------------------------------------------------
module rv64im_decode_execute #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_instruction,
    input  logic [63:0] i_pc,
    input  logic [63:0] i_rs1_value,
    input  logic [63:0] i_rs2_value,
    output logic        o_valid,
    output logic [4:0]  o_dest_reg,
    output logic        o_write_reg,
    output logic [63:0] o_result,
    output logic [63:0] o_store_data,
    output logic [63:0] o_next_pc,
    output logic        o_redirect,
    output logic        o_illegal,
    output logic [1:0]  o_mem_kind,
    output logic [1:0]  o_mem_size,
    output logic        o_load_signed,
    output logic        o_system_call,
    output logic        o_long_latency
);
    import rvd_pkg::*;

    t_uop dec_uop;
    t_uop head;
    logic empty;
    logic full;
    logic pop;

    assign busy = full;

    rvd_decode u_dec (
        .i_instruction (i_instruction),
        .i_pc          (i_pc),
        .i_rs1_value   (i_rs1_value),
        .i_rs2_value   (i_rs2_value),
        .o_uop         (dec_uop)
    );

    rvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !full),
        .i_uop   (dec_uop),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    rvd_execute u_ex (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_dest_reg     (o_dest_reg),
        .o_write_reg    (o_write_reg),
        .o_result       (o_result),
        .o_store_data   (o_store_data),
        .o_next_pc      (o_next_pc),
        .o_redirect     (o_redirect),
        .o_illegal      (o_illegal),
        .o_mem_kind     (o_mem_kind),
        .o_mem_size     (o_mem_size),
        .o_load_signed  (o_load_signed),
        .o_system_call  (o_system_call),
        .o_long_latency (o_long_latency)
    );

endmodule

// ===== rtl/rvd_decode.sv =====
// ----------------------------------------------------------------------------
// rvd_decode
// front end: classifies an instruction word into an execute micro-op
// ----------------------------------------------------------------------------
module rvd_decode (
    input  logic [31:0]  i_instruction,
    input  logic [63:0]  i_pc,
    input  logic [63:0]  i_rs1_value,
    input  logic [63:0]  i_rs2_value,
    output rvd_pkg::t_uop o_uop
);
    import rvd_pkg::*;

    logic [31:0] ins;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] imm_u;
    logic [63:0] imm_j;

    assign ins   = i_instruction;
    assign opc   = ins[6:0];
    assign f3    = ins[14:12];
    assign f7    = ins[31:25];
    assign imm_i = {{52{ins[31]}}, ins[31:20]};
    assign imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_u = {{32{ins[31]}}, ins[31:12], 12'b0};
    assign imm_j = {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};

    always_comb begin
        t_uop        u;
        logic [63:0] tbase;
        logic [63:0] toff;
        logic [63:0] tsum;
        logic        clr0;
        u            = '0;
        u.op         = OP_NONE;
        u.opa        = i_rs1_value;
        u.opb        = i_rs2_value;
        u.link       = i_pc + 64'd4;
        tbase        = i_pc;
        toff         = imm_b;
        clr0         = 1'b0;
        case (opc)
            OPC_OP: begin
                u.info.dest_reg  = ins[11:7];
                u.info.write_reg = 1'b1;
                if (f7 == F7_MULDIV && f3 == 3'd0) begin
                    u.op = OP_MUL;
                    u.info.long_latency = 1'b1;
                end else if (f7 == F7_MULDIV && f3 == 3'd4) begin
                    u.op = OP_DIV;
                    u.info.long_latency = 1'b1;
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    u.op = OP_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    u.op = OP_SRA;
                end else if (f7 != F7_BASE) begin
                    u.info.illegal = 1'b1;
                end else begin
                    case (f3)
                        3'd0:    u.op = OP_ADD;
                        3'd1:    u.op = OP_SLL;
                        3'd2:    u.op = OP_SLT;
                        3'd3:    u.op = OP_SLTU;
                        3'd4:    u.op = OP_XOR;
                        3'd5:    u.op = OP_SRL;
                        3'd6:    u.op = OP_OR;
                        default: u.op = OP_AND;
                    endcase
                end
            end
            OPC_OPIMM: begin
                u.info.dest_reg  = ins[11:7];
                u.info.write_reg = 1'b1;
                u.opb            = imm_i;
                case (f3)
                    3'd0: u.op = OP_ADD;
                    3'd2: u.op = OP_SLT;
                    3'd3: u.op = OP_SLTU;
                    3'd4: u.op = OP_XOR;
                    3'd6: u.op = OP_OR;
                    3'd7: u.op = OP_AND;
                    3'd1: begin
                        if (ins[31:26] != 6'd0) u.info.illegal = 1'b1;
                        else                    u.op = OP_SLL;
                    end
                    default: begin
                        if (ins[31:26] == 6'd0)        u.op = OP_SRL;
                        else if (ins[31:26] == SH_ALT) u.op = OP_SRA;
                        else                           u.info.illegal = 1'b1;
                    end
                endcase
            end
            OPC_OPIMMW, OPC_OPW: begin
                u.info.dest_reg  = ins[11:7];
                u.info.write_reg = 1'b1;
                if (opc == OPC_OPIMMW) begin
                    u.opb = imm_i;
                end
                if (f3 == 3'd0 && (opc == OPC_OPIMMW || f7 == F7_BASE)) u.op = OP_ADDW;
                else if (f3 == 3'd0 && f7 == F7_ALT && opc == OPC_OPW)   u.op = OP_SUBW;
                else if (f3 == 3'd1 && f7 == F7_BASE)                   u.op = OP_SLLW;
                else if (f3 == 3'd5 && f7 == F7_BASE)                   u.op = OP_SRLW;
                else if (f3 == 3'd5 && f7 == F7_ALT)                    u.op = OP_SRAW;
                else                                                    u.info.illegal = 1'b1;
            end
            OPC_LUI: begin
                u.info.dest_reg  = ins[11:7];
                u.info.write_reg = 1'b1;
                u.op  = OP_ADD;
                u.opa = '0;
                u.opb = imm_u;
            end
            OPC_AUIPC: begin
                u.info.dest_reg  = ins[11:7];
                u.info.write_reg = 1'b1;
                u.op  = OP_ADD;
                u.opa = i_pc;
                u.opb = imm_u;
            end
            OPC_JAL: begin
                u.info.dest_reg  = ins[11:7];
                u.info.write_reg = 1'b1;
                u.op  = OP_LINK;
                toff  = imm_j;
            end
            OPC_JALR: begin
                if (f3 != 3'd0) begin
                    u.info.illegal = 1'b1;
                end else begin
                    u.info.dest_reg  = ins[11:7];
                    u.info.write_reg = 1'b1;
                    u.op  = OP_LINK;
                    tbase = i_rs1_value;
                    toff  = imm_i;
                    clr0  = 1'b1;
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0:    u.op = OP_BEQ;
                    3'd1:    u.op = OP_BNE;
                    3'd4:    u.op = OP_BLT;
                    3'd5:    u.op = OP_BGE;
                    3'd6:    u.op = OP_BLTU;
                    3'd7:    u.op = OP_BGEU;
                    default: u.info.illegal = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                if (f3 == 3'd7) begin
                    u.info.illegal = 1'b1;
                end else begin
                    u.info.dest_reg    = ins[11:7];
                    u.info.write_reg   = 1'b1;
                    u.op               = OP_ADD;
                    u.opb              = imm_i;
                    u.info.mem_kind    = MEM_LOAD;
                    u.info.mem_size    = f3[1:0];
                    u.info.load_signed = ~f3[2];
                end
            end
            OPC_STORE: begin
                if (f3[2]) begin
                    u.info.illegal = 1'b1;
                end else begin
                    u.op            = OP_ADD;
                    u.opb           = imm_s;
                    u.info.mem_kind = MEM_STORE;
                    u.info.mem_size = f3[1:0];
                    case (f3[1:0])
                        2'd0:    u.store_data = {56'd0, i_rs2_value[7:0]};
                        2'd1:    u.store_data = {48'd0, i_rs2_value[15:0]};
                        2'd2:    u.store_data = {32'd0, i_rs2_value[31:0]};
                        default: u.store_data = i_rs2_value;
                    endcase
                end
            end
            OPC_SYSTEM: begin
                if (ins != ECALL_WORD) begin
                    u.info.illegal = 1'b1;
                end else begin
                    u.info.dest_reg    = REG_A0;
                    u.info.system_call = 1'b1;
                end
            end
            default: u.info.illegal = 1'b1;
        endcase
        tsum     = tbase + toff;
        u.target = {tsum[63:1], tsum[0] & ~clr0};
        if (u.info.illegal) begin
            u.op         = OP_NONE;
            u.info       = '0;
            u.info.illegal = 1'b1;
            u.store_data = '0;
        end
        o_uop = u;
    end

endmodule

// ===== rtl/rvd_queue.sv =====
// ----------------------------------------------------------------------------
// rvd_queue
// small micro-op fifo between decode and execute
// ----------------------------------------------------------------------------
module rvd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rvd_pkg::t_uop i_uop,
    input  logic          i_pop,
    output rvd_pkg::t_uop o_head,
    output logic          o_empty,
    output logic          o_full
);
    import rvd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_uop          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_uop;
        end
    end

endmodule

// ===== rtl/rvd_execute.sv =====
// ----------------------------------------------------------------------------
// rvd_execute
// back end: alu, branch resolve, split multiplier and radix-2 divider
// ----------------------------------------------------------------------------
module rvd_execute (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rvd_pkg::t_uop i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    output logic [4:0]    o_dest_reg,
    output logic          o_write_reg,
    output logic [63:0]   o_result,
    output logic [63:0]   o_store_data,
    output logic [63:0]   o_next_pc,
    output logic          o_redirect,
    output logic          o_illegal,
    output logic [1:0]    o_mem_kind,
    output logic [1:0]    o_mem_size,
    output logic          o_load_signed,
    output logic          o_system_call,
    output logic          o_long_latency
);
    import rvd_pkg::*;

    localparam logic [6:0] DIV_STEPS = 7'd64;

    // output stage
    logic        r_v;
    t_info       r_info;
    logic [63:0] r_res;
    logic [63:0] r_sdata;
    logic [63:0] r_npc;
    logic        r_redir;
    logic        r_is_mul;
    logic [63:0] r_pp0;
    logic [31:0] r_pp1;
    logic [31:0] r_pp2;

    // divider
    logic        r_dbusy;
    logic [6:0]  r_dcnt;
    logic [63:0] r_drem;
    logic [63:0] r_dquo;
    logic [63:0] r_ddiv;
    logic        r_dneg;
    logic        r_dspec;
    logic [63:0] r_dspec_val;
    t_info       r_dinfo;
    logic [63:0] r_dlink;

    t_uop        h;
    logic [63:0] alu;
    logic        taken;
    logic        is_branch;
    logic [31:0] w32;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [64:0] dshift;
    logic [64:0] ddiff;
    logic        dfin;
    logic [63:0] dq;

    assign h     = i_head;
    assign o_pop = !i_empty && !r_dbusy;
    assign dfin  = r_dbusy && (r_dcnt == DIV_STEPS);

    always_comb begin
        alu       = '0;
        w32       = '0;
        taken     = 1'b0;
        is_branch = 1'b0;
        case (h.op)
            OP_ADD:  alu = h.opa + h.opb;
            OP_SUB:  alu = h.opa - h.opb;
            OP_SLL:  alu = h.opa << h.opb[5:0];
            OP_SLT:  alu = {63'd0, $signed(h.opa) < $signed(h.opb)};
            OP_SLTU: alu = {63'd0, h.opa < h.opb};
            OP_XOR:  alu = h.opa ^ h.opb;
            OP_SRL:  alu = h.opa >> h.opb[5:0];
            OP_SRA:  alu = $unsigned($signed(h.opa) >>> h.opb[5:0]);
            OP_OR:   alu = h.opa | h.opb;
            OP_AND:  alu = h.opa & h.opb;
            OP_ADDW: w32 = h.opa[31:0] + h.opb[31:0];
            OP_SUBW: w32 = h.opa[31:0] - h.opb[31:0];
            OP_SLLW: w32 = h.opa[31:0] << h.opb[4:0];
            OP_SRLW: w32 = h.opa[31:0] >> h.opb[4:0];
            OP_SRAW: w32 = $unsigned($signed(h.opa[31:0]) >>> h.opb[4:0]);
            OP_LINK: alu = h.link;
            OP_BEQ:  begin is_branch = 1'b1; taken = (h.opa == h.opb); end
            OP_BNE:  begin is_branch = 1'b1; taken = (h.opa != h.opb); end
            OP_BLT:  begin is_branch = 1'b1; taken = $signed(h.opa) < $signed(h.opb); end
            OP_BGE:  begin is_branch = 1'b1; taken = !($signed(h.opa) < $signed(h.opb)); end
            OP_BLTU: begin is_branch = 1'b1; taken = (h.opa < h.opb); end
            OP_BGEU: begin is_branch = 1'b1; taken = !(h.opa < h.opb); end
            default: alu = '0;
        endcase
        if (h.op inside {OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW}) begin
            alu = {{32{w32[31]}}, w32};
        end
    end

    assign ma     = h.opa[63] ? (64'd0 - h.opa) : h.opa;
    assign mb     = h.opb[63] ? (64'd0 - h.opb) : h.opb;
    assign dshift = {r_drem, r_dquo[63]};
    assign ddiff  = dshift - {1'b0, r_ddiv};
    assign dq     = r_dspec ? r_dspec_val : (r_dneg ? (64'd0 - r_dquo) : r_dquo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_v <= (o_pop && h.op != OP_DIV) || dfin;
            if (o_pop && h.op == OP_DIV) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (dfin) begin
                r_dbusy <= 1'b0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && h.op == OP_DIV) begin
            r_drem      <= '0;
            r_dquo      <= ma;
            r_ddiv      <= mb;
            r_dneg      <= h.opa[63] ^ h.opb[63];
            r_dspec     <= (h.opb == '0) ||
                           (h.opa == {1'b1, 63'd0} && h.opb == '1);
            r_dspec_val <= (h.opb == '0) ? '1 : h.opa;
            r_dinfo     <= h.info;
            r_dlink     <= h.link;
        end else if (r_dbusy && !dfin) begin
            if (!ddiff[64]) begin
                r_drem <= ddiff[63:0];
            end else begin
                r_drem <= dshift[63:0];
            end
            r_dquo <= {r_dquo[62:0], ~ddiff[64]};
        end
        if (dfin) begin
            r_info   <= r_dinfo;
            r_res    <= dq;
            r_sdata  <= '0;
            r_npc    <= r_dlink;
            r_redir  <= 1'b0;
            r_is_mul <= 1'b0;
        end else if (o_pop) begin
            r_info   <= h.info;
            r_res    <= is_branch ? '0 : alu;
            r_sdata  <= h.store_data;
            r_redir  <= (h.op == OP_LINK) || taken;
            r_npc    <= ((h.op == OP_LINK) || taken) ? h.target : h.link;
            r_is_mul <= (h.op == OP_MUL);
            r_pp0    <= h.opa[31:0] * h.opb[31:0];
            r_pp1    <= 32'(h.opa[31:0] * h.opb[63:32]);
            r_pp2    <= 32'(h.opa[63:32] * h.opb[31:0]);
        end
    end

    assign o_valid        = r_v;
    assign o_dest_reg     = r_info.dest_reg;
    assign o_write_reg    = r_info.write_reg;
    assign o_result       = r_is_mul ? (r_pp0 + {r_pp1 + r_pp2, 32'd0}) : r_res;
    assign o_store_data   = r_sdata;
    assign o_next_pc      = r_npc;
    assign o_redirect     = r_redir;
    assign o_illegal      = r_info.illegal;
    assign o_mem_kind     = r_info.mem_kind;
    assign o_mem_size     = r_info.mem_size;
    assign o_load_signed  = r_info.load_signed;
    assign o_system_call  = r_info.system_call;
    assign o_long_latency = r_info.long_latency;

endmodule
